FILE: hdl/assert_macros.svh
// Assertion macros shared by the command line editor RTL.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: hdl/cle_pkg.sv
// Package for the command line editor: sizes, key codes and the
// controller/datapath interface structs. No dependencies.
package cle_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int STORE_DEPTH  = 64;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
    localparam int LINE_CAP     = (BUFFER_BYTES - 3 > STORE_DEPTH) ? STORE_DEPTH
                                                                 : BUFFER_BYTES - 3;

    localparam logic [1:0] OP_KEY       = 2'd0;
    localparam logic [1:0] OP_BACKSPACE = 2'd1;
    localparam logic [1:0] OP_RETURN    = 2'd2;

    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7E;

    // Controller to datapath.
    typedef struct packed {
        logic append;     // write the key character at the line end
        logic backspace;  // drop the last character
        logic load;       // load the next output word
        logic clear;      // empty the line, rewind the read index
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic char_ok;    // key character is printable and the line has room
        logic out_free;   // output register can take a word this cycle
        logic at_last;    // the word about to be loaded ends the line
    } t_dp_status;

endpackage

FILE: hdl/cle_datapath.sv
// Datapath of the command line editor: line store, character count,
// read index and output register. Depends on cle_pkg.
module cle_datapath
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_char_code,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_empty_line,
    output logic       o_out_last
);

    logic [7:0]        r_store [STORE_DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_char;
    logic              r_out_empty, r_out_last;

    logic              printable;
    logic              count_zero;
    logic              idx_last;

    always_comb begin
        printable  = i_char_code inside {[CHAR_FIRST:CHAR_LAST]};
        count_zero = (r_count == '0);
        idx_last   = ({1'b0, r_rd_idx} + CNT_W'(1)) == r_count;

        o_status.char_ok  = printable && (r_count < CNT_W'(LINE_CAP));
        o_status.out_free = !r_out_valid || !i_out_stall;
        o_status.at_last  = count_zero || idx_last;
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.append) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.backspace && !count_zero) begin
            n_count = r_count - CNT_W'(1);
        end

        n_rd_idx = r_rd_idx;
        if (i_cmd.clear) begin
            n_rd_idx = '0;
        end else if (i_cmd.load) begin
            n_rd_idx = r_rd_idx + ADDR_W'(1);
        end

        n_out_valid = r_out_valid;
        if (i_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Line store write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_store[r_count[ADDR_W-1:0]] <= i_char_code;
        end
    end

    // Registered read straight into the output word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (count_zero) begin
                r_out_char  <= 8'h00;
                r_out_empty <= 1'b1;
                r_out_last  <= 1'b1;
            end else begin
                r_out_char  <= r_store[r_rd_idx];
                r_out_empty <= 1'b0;
                r_out_last  <= idx_last;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_char       = r_out_char;
    assign o_out_empty_line = r_out_empty;
    assign o_out_last       = r_out_last;

endmodule

FILE: hdl/cle_ctrl.sv
// Controller of the command line editor: decodes key words and sequences
// the read-out of a finished line. Depends on cle_pkg.
module cle_ctrl
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_operation,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        accept     = i_in_valid && !o_in_stall;
        n_state    = r_state;
        o_cmd      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_BACKSPACE: o_cmd.backspace = 1'b1;
                        OP_RETURN:    n_state = S_EMIT;
                        default:      o_cmd.append = i_status.char_ok;
                    endcase
                end
            end
            S_EMIT: begin
                // Advance one word whenever the output register frees up.
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_status.at_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/command_line_editor_core.sv
// Top level of the command line editor: controller plus datapath.
// Depends on cle_pkg, cle_ctrl, cle_datapath and assert_macros.svh.
//
//  channel   direction  handshake                 payload
//  ------    ---------  ------------------------  ---------------------------------
//  in        sink       i_in_valid / o_in_stall   i_operation, i_char_code
//  out       source     o_out_valid / i_out_stall o_out_char, o_out_empty_line,
//                                                 o_out_last
//
// Key and backspace words are handled as they are accepted. A return word starts
// the read-out of one output word per character (n characters, or one
// word for an empty line); while the output is not stalled, the line store
// read port delivers one character a cycle into the output register.
// Reset is synchronous, active low; the line store itself is not cleared.
// Input stalls only while a line is read out; output stalls hold the
// current word and pause the read-out.
`include "assert_macros.svh"

module command_line_editor_core
    import cle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_out_empty_line,
    output logic       o_out_last
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Key decode and read-out sequencing.
    cle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Line store, count and output word.
    cle_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char_code      (i_char_code),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_out_char       (o_out_char),
        .o_out_empty_line (o_out_empty_line),
        .o_out_last       (o_out_last)
    );

    // An empty-line word is always the only word of its line.
    `CLE_ASSERT(a_empty_is_last, !(o_out_valid && o_out_empty_line) || (o_out_last && o_out_char == 8'h00), "empty-line word without last or with a character")
    // An accepted return word must hold off input while the line drains.
    `CLE_ASSERT(a_return_stalls, (i_in_valid && !o_in_stall && i_operation == OP_RETURN) |=> o_in_stall, "input not stalled after return")
    // Input reopens only once the final word of the line is in the output register.
    `CLE_ASSERT(a_reopen_on_last, $fell(o_in_stall) |-> (o_out_valid && o_out_last), "input reopened before the last word")
    // Append and read-out never overlap.
    `CLE_ASSERT_ALWAYS(a_no_append_in_emit, !(dp_cmd.append && dp_cmd.load), "append during read-out")

endmodule
